>>> design/cat_pkg.sv
// shared types, codes and limits for the cron alarm table
// no dependencies; used by cat_match and cron_alarm_table
package cat_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int TAG_BITS    = 16;
    localparam int ID_BITS     = 16;

    localparam int MINUTE_LIMIT  = 59;
    localparam int HOUR_LIMIT    = 23;
    localparam int DAY_LIMIT     = 31;
    localparam int MONTH_LIMIT   = 12;
    localparam int WEEKDAY_LIMIT = 6;

    // widths of the packed calendar fields and the index spans they reach
    localparam int MIN_IDX_W  = 6;
    localparam int HOUR_IDX_W = 5;
    localparam int DAY_IDX_W  = 5;
    localparam int MON_IDX_W  = 4;
    localparam int WDAY_IDX_W = 3;

    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_ADD    = 2'd0;
    localparam cmd_t CMD_REMOVE = 2'd1;
    localparam cmd_t CMD_TICK   = 2'd2;

    typedef logic [1:0] status_t;
    localparam status_t STAT_OK        = 2'd0;
    localparam status_t STAT_DUPLICATE = 2'd1;
    localparam status_t STAT_FULL      = 2'd2;
    localparam status_t STAT_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic                     weekday_wild;
        logic                     day_wild;
        logic [WEEKDAY_LIMIT:0]   weekday;
        logic [MONTH_LIMIT:0]     month;
        logic [DAY_LIMIT:0]       day;
        logic [HOUR_LIMIT:0]      hour;
        logic [MINUTE_LIMIT:0]    minute;
    } sched_t;

    typedef struct packed {
        logic [WDAY_IDX_W-1:0]    weekday;
        logic [MON_IDX_W-1:0]     month;
        logic [DAY_IDX_W-1:0]     day;
        logic [HOUR_IDX_W-1:0]    hour;
        logic [MIN_IDX_W-1:0]     minute;
    } cal_time_t;

endpackage

>>> design/cat_match.sv
// schedule test of one table entry against a calendar minute
// depends on cat_pkg for the entry and time layouts
module cat_match
(
    input  cat_pkg::sched_t    sched,
    input  cat_pkg::cal_time_t cal,
    output logic               hit
);

    // masks widened so every index code lands on a real bit; the extra bits are zero
    logic [2**cat_pkg::MIN_IDX_W-1:0]  min_ext;
    logic [2**cat_pkg::HOUR_IDX_W-1:0] hour_ext;
    logic [2**cat_pkg::DAY_IDX_W-1:0]  day_ext;
    logic [2**cat_pkg::MON_IDX_W-1:0]  mon_ext;
    logic [2**cat_pkg::WDAY_IDX_W-1:0] wday_ext;
    logic dom_ok;
    logic dow_ok;
    logic day_ok;

    always_comb
    begin
        min_ext  = (2**cat_pkg::MIN_IDX_W)'(sched.minute);
        hour_ext = (2**cat_pkg::HOUR_IDX_W)'(sched.hour);
        day_ext  = (2**cat_pkg::DAY_IDX_W)'(sched.day);
        mon_ext  = (2**cat_pkg::MON_IDX_W)'(sched.month);
        wday_ext = (2**cat_pkg::WDAY_IDX_W)'(sched.weekday);

        dom_ok = day_ext[cal.day];
        dow_ok = wday_ext[cal.weekday];
        // both fields restricted: either one may match
        if (!sched.day_wild && !sched.weekday_wild)
        begin
            day_ok = dom_ok | dow_ok;
        end
        else
        begin
            day_ok = dom_ok & dow_ok;
        end

        hit = mon_ext[cal.month] & day_ok & hour_ext[cal.hour] & min_ext[cal.minute];
    end

endmodule

>>> design/cron_alarm_table.sv
// cron alarm table: entries in one synchronous ram, scanned one per cycle unless the output stalls a tick
// add, remove and tick walk the entries through the single ram read port,
// and an unused command goes straight to its status beat
// one item at a time; a tick scan holds on a firing entry only when the output stalls
// reset clears the entry count and control; ram contents stay undefined until written
// depends on cat_pkg and cat_match
module cron_alarm_table
#(
    parameter int MAX_ENTRIES = cat_pkg::MAX_ENTRIES,
    parameter int TAG_BITS    = cat_pkg::TAG_BITS
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // entry_id, minute_mask, hour_mask, day_mask, month_mask, weekday_mask,
    // day_wild, weekday_wild, calendar_time, zero pad
    input  logic [183:0] s_axis_tdata,
    // command
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // fired_id
    output logic [15:0]  m_axis_tdata,
    // status, fired
    output logic [2:0]   m_axis_tuser,
    output logic         m_axis_tlast
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int EW = TAG_BITS + $bits(cat_pkg::sched_t);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_MOVE = 3'd2;
    localparam logic [2:0] ST_DONE = 3'd3;

    logic [2:0]                  state_reg, state_next;
    logic [CW-1:0]               cnt_reg, cnt_next;
    logic [CW-1:0]               idx_reg, idx_next;
    logic [AW-1:0]               hit_idx_reg, hit_idx_next;
    cat_pkg::status_t            status_reg, status_next;
    logic                        pend_valid_reg, pend_valid_next;
    logic [TAG_BITS-1:0]         pend_id_reg, pend_id_next;

    cat_pkg::cmd_t               cmd_reg;
    logic [TAG_BITS-1:0]         tag_reg;
    cat_pkg::sched_t             sched_reg;
    cat_pkg::cal_time_t          cal_reg;

    logic                        ov_reg;
    cat_pkg::status_t            o_status_reg;
    logic                        o_fired_reg;
    logic [cat_pkg::ID_BITS-1:0] o_id_reg;
    logic                        o_last_reg;

    logic [EW-1:0]               mem_ram [MAX_ENTRIES];
    logic [EW-1:0]               rd_data_reg;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [EW-1:0]               wr_data;

    logic                        accept;
    logic                        out_free;
    logic                        push;
    cat_pkg::status_t            push_status;
    logic                        push_fired;
    logic [TAG_BITS-1:0]         push_id;
    logic                        push_last;

    logic [TAG_BITS-1:0]         rd_tag;
    cat_pkg::sched_t             rd_sched;
    logic                        sched_hit;
    logic                        tag_hit;
    logic [CW-1:0]               idx_inc;
    logic [CW-1:0]               cnt_dec;
    cat_pkg::sched_t             sched_in;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid & s_axis_tready;
    assign out_free      = !ov_reg || m_axis_tready;

    assign rd_tag   = rd_data_reg[EW-1 -: TAG_BITS];
    assign rd_sched = cat_pkg::sched_t'(rd_data_reg[$bits(cat_pkg::sched_t)-1:0]);
    assign tag_hit  = (rd_tag == tag_reg);
    assign idx_inc  = idx_reg + 1'b1;
    assign cnt_dec  = cnt_reg - 1'b1;

    // day and month bit 0 never count
    always_comb
    begin
        sched_in.minute       = s_axis_tdata[75:16];
        sched_in.hour         = s_axis_tdata[99:76];
        sched_in.day          = s_axis_tdata[131:100] & ~32'd1;
        sched_in.month        = s_axis_tdata[144:132] & ~13'd1;
        sched_in.weekday      = s_axis_tdata[151:145];
        sched_in.day_wild     = s_axis_tdata[152];
        sched_in.weekday_wild = s_axis_tdata[153];
    end

    cat_match u_match
    (
        .sched (rd_sched),
        .cal   (cal_reg),
        .hit   (sched_hit)
    );

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        hit_idx_next    = hit_idx_reg;
        status_next     = status_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        rd_en           = 1'b0;
        rd_addr         = idx_inc[AW-1:0];
        wr_en           = 1'b0;
        wr_addr         = cnt_reg[AW-1:0];
        wr_data         = {tag_reg, sched_reg};
        push            = 1'b0;
        push_status     = cat_pkg::STAT_OK;
        push_fired      = 1'b0;
        push_id         = '0;
        push_last       = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    status_next     = cat_pkg::STAT_OK;
                    pend_valid_next = 1'b0;
                    idx_next        = '0;
                    if (s_axis_tuser == cat_pkg::CMD_ADD || s_axis_tuser == cat_pkg::CMD_REMOVE
                        || s_axis_tuser == cat_pkg::CMD_TICK)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (idx_reg == cnt_reg)
                begin
                    // walked past the last entry
                    state_next = ST_DONE;
                    case (cmd_reg)
                        cat_pkg::CMD_ADD:
                        begin
                            if (cnt_reg == CW'(MAX_ENTRIES))
                            begin
                                status_next = cat_pkg::STAT_FULL;
                            end
                            else
                            begin
                                wr_en    = 1'b1;
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        cat_pkg::CMD_REMOVE:
                        begin
                            status_next = cat_pkg::STAT_NOT_FOUND;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else
                begin
                    case (cmd_reg)
                        cat_pkg::CMD_ADD:
                        begin
                            if (tag_hit)
                            begin
                                status_next = cat_pkg::STAT_DUPLICATE;
                                state_next  = ST_DONE;
                            end
                            else
                            begin
                                idx_next = idx_inc;
                                rd_en    = 1'b1;
                            end
                        end
                        cat_pkg::CMD_REMOVE:
                        begin
                            if (tag_hit)
                            begin
                                // fetch the last entry to fill the gap
                                hit_idx_next = idx_reg[AW-1:0];
                                rd_en        = 1'b1;
                                rd_addr      = cnt_dec[AW-1:0];
                                state_next   = ST_MOVE;
                            end
                            else
                            begin
                                idx_next = idx_inc;
                                rd_en    = 1'b1;
                            end
                        end
                        default:
                        begin
                            // tick: hold one hit back so the final one can carry tlast
                            if (!sched_hit)
                            begin
                                idx_next = idx_inc;
                                rd_en    = 1'b1;
                            end
                            else if (!pend_valid_reg)
                            begin
                                pend_valid_next = 1'b1;
                                pend_id_next    = rd_tag;
                                idx_next        = idx_inc;
                                rd_en           = 1'b1;
                            end
                            else if (out_free)
                            begin
                                push         = 1'b1;
                                push_fired   = 1'b1;
                                push_id      = pend_id_reg;
                                push_last    = 1'b0;
                                pend_id_next = rd_tag;
                                idx_next     = idx_inc;
                                rd_en        = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_MOVE:
            begin
                wr_en       = 1'b1;
                wr_addr     = hit_idx_reg;
                wr_data     = rd_data_reg;
                cnt_next    = cnt_dec;
                status_next = cat_pkg::STAT_OK;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    push            = 1'b1;
                    push_status     = status_reg;
                    push_fired      = pend_valid_reg;
                    push_id         = pend_valid_reg ? pend_id_reg : '0;
                    push_last       = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_ram[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_ram[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            ov_reg         <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            if (push)
            begin
                ov_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hit_idx_reg <= hit_idx_next;
        status_reg  <= status_next;
        pend_id_reg <= pend_id_next;
        if (accept)
        begin
            cmd_reg   <= s_axis_tuser;
            tag_reg   <= TAG_BITS'(s_axis_tdata[15:0]);
            sched_reg <= sched_in;
            cal_reg   <= cat_pkg::cal_time_t'(s_axis_tdata[176:154]);
        end
        if (push)
        begin
            o_status_reg <= push_status;
            o_fired_reg  <= push_fired;
            o_id_reg     <= cat_pkg::ID_BITS'(push_id);
            o_last_reg   <= push_last;
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = o_id_reg;
    assign m_axis_tuser  = {o_fired_reg, o_status_reg};
    assign m_axis_tlast  = o_last_reg;

    // the table never holds more than its depth
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_ENTRIES))
        else $error("entry count above table depth");

    // a held-back hit only exists while a tick is being worked on
    a_pend_tick: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (cmd_reg == cat_pkg::CMD_TICK))
        else $error("pending hit outside a tick");

    // the count moves only at the end of a scan or after a gap fill
    a_cnt_change: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(cnt_reg) |-> ($past(state_reg) == ST_SCAN || $past(state_reg) == ST_MOVE))
        else $error("entry count changed outside add or remove");

    // a gap fill always targets a live entry
    a_move_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOVE) |-> (CW'(hit_idx_reg) < cnt_reg))
        else $error("gap fill outside the live entries");

endmodule

>>> sim/tb_cron_alarm_table.sv
// testbench for cron_alarm_table: directed table, then random add/remove/tick/unused traffic
// results are checked beat by beat against a behavioral copy of the alarm table
// depends on cat_pkg and the design sources
`timescale 1ns / 100ps

module tb_cron_alarm_table;

    localparam cat_pkg::cmd_t CMD_UNUSED = 2'd3;
    localparam int   TAG_POOL      = 40;
    localparam int   RANDOM_ITEMS  = 296;
    localparam int   DRAIN_CYCLES  = cat_pkg::MAX_ENTRIES + 8;
    localparam int   LONG_HOLD     = 400;
    localparam int   HOLD_AFTER    = 80;

    typedef struct {
        cat_pkg::cmd_t      cmd;
        logic [15:0]        tag;
        cat_pkg::sched_t    sched;
        cat_pkg::cal_time_t when;
    } alarm_item_t;

    typedef struct {
        cat_pkg::status_t status;
        logic             fired;
        logic [15:0]      tag;
        logic             last;
    } alarm_result_t;

    typedef struct {
        alarm_item_t      item;
        bit               typed;
        cat_pkg::status_t want;
    } plan_row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [183:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [15:0]  m_axis_tdata;
    logic [2:0]   m_axis_tuser;
    logic         m_axis_tlast;

    // behavioral copy of the table
    logic [15:0]     table_tag [cat_pkg::MAX_ENTRIES];
    cat_pkg::sched_t table_sched [cat_pkg::MAX_ENTRIES];
    int              table_count = 0;
    alarm_result_t   pending_results [$];
    logic [15:0]     tag_pool [TAG_POOL];
    int              mismatch_count = 0;
    int              results_seen = 0;

    cron_alarm_table DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #(15_000_000);
        $display("Mismatches found");
        $finish;
    end

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at %0t ns: %s got %0h want %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic cat_pkg::cal_time_t cal_at(int wd, int mo, int dy, int hr, int mi);
        cat_pkg::cal_time_t t;
        t.weekday = wd[cat_pkg::WDAY_IDX_W-1:0];
        t.month   = mo[cat_pkg::MON_IDX_W-1:0];
        t.day     = dy[cat_pkg::DAY_IDX_W-1:0];
        t.hour    = hr[cat_pkg::HOUR_IDX_W-1:0];
        t.minute  = mi[cat_pkg::MIN_IDX_W-1:0];
        return t;
    endfunction

    function automatic logic entry_hits(int i, cat_pkg::cal_time_t t);
        cat_pkg::sched_t e;
        logic            dom;
        logic            dow;
        logic            day_ok;
        e = table_sched[i];
        if (t.month > cat_pkg::MONTH_LIMIT || !e.month[t.month])
            return 1'b0;
        dom = e.day[t.day];
        dow = (t.weekday <= cat_pkg::WEEKDAY_LIMIT) && e.weekday[t.weekday];
        // both restricted: either test will do; any star: both must pass
        day_ok = (e.day_wild || e.weekday_wild) ? (dom && dow) : (dom || dow);
        if (!day_ok)
            return 1'b0;
        if (t.hour > cat_pkg::HOUR_LIMIT || !e.hour[t.hour])
            return 1'b0;
        return (t.minute <= cat_pkg::MINUTE_LIMIT) && e.minute[t.minute];
    endfunction

    // updates the table copy and queues the beats the item should produce
    function automatic void apply_to_table(alarm_item_t it);
        alarm_result_t r;
        alarm_result_t f;
        int            hit;
        int            fires;
        r = '{cat_pkg::STAT_OK, 1'b0, 16'h0, 1'b1};
        hit = -1;
        for (int i = 0; i < table_count; i++)
            if (table_tag[i] == it.tag && hit < 0)
                hit = i;
        case (it.cmd)
            cat_pkg::CMD_ADD:
            begin
                if (hit >= 0)
                    r.status = cat_pkg::STAT_DUPLICATE;
                else if (table_count >= cat_pkg::MAX_ENTRIES)
                    r.status = cat_pkg::STAT_FULL;
                else
                begin
                    table_tag[table_count] = it.tag;
                    table_sched[table_count] = it.sched;
                    table_sched[table_count].day[0] = 1'b0;
                    table_sched[table_count].month[0] = 1'b0;
                    table_count++;
                end
                pending_results.push_back(r);
            end
            cat_pkg::CMD_REMOVE:
            begin
                if (hit < 0)
                    r.status = cat_pkg::STAT_NOT_FOUND;
                else
                begin
                    // last entry moves into the gap
                    table_tag[hit] = table_tag[table_count-1];
                    table_sched[hit] = table_sched[table_count-1];
                    table_count--;
                end
                pending_results.push_back(r);
            end
            cat_pkg::CMD_TICK:
            begin
                fires = 0;
                for (int i = 0; i < table_count; i++)
                begin
                    if (entry_hits(i, it.when))
                    begin
                        f = '{cat_pkg::STAT_OK, 1'b1, table_tag[i], 1'b0};
                        pending_results.push_back(f);
                        fires++;
                    end
                end
                if (fires == 0)
                    pending_results.push_back(r);
                else
                    pending_results[pending_results.size()-1].last = 1'b1;
            end
            default:
                pending_results.push_back(r);
        endcase
    endfunction

    function automatic logic [63:0] pick_bits();
        logic [63:0] a;
        logic [63:0] b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(3))
            0:       return '1;
            1:       return a;
            2:       return a | b;
            default: return a & b;
        endcase
    endfunction

    function automatic alarm_item_t random_item(bit growing);
        alarm_item_t it;
        logic [63:0] bits;
        int          r;
        r = $urandom_range(99);
        it.tag = tag_pool[$urandom_range(TAG_POOL-1)];
        if (r < (growing ? 55 : 15))
            it.cmd = cat_pkg::CMD_ADD;
        else if (r < (growing ? 70 : 55))
        begin
            it.cmd = cat_pkg::CMD_REMOVE;
            if (table_count > 0 && $urandom_range(3) != 0)
                it.tag = table_tag[$urandom_range(table_count-1)];
        end
        else if (r < 97)
            it.cmd = cat_pkg::CMD_TICK;
        else
            it.cmd = CMD_UNUSED;
        bits = pick_bits();
        it.sched.minute = bits[cat_pkg::MINUTE_LIMIT:0];
        bits = pick_bits();
        it.sched.hour = bits[cat_pkg::HOUR_LIMIT:0];
        bits = pick_bits();
        it.sched.day = bits[cat_pkg::DAY_LIMIT:0];
        bits = pick_bits();
        it.sched.month = bits[cat_pkg::MONTH_LIMIT:0];
        bits = pick_bits();
        it.sched.weekday = bits[cat_pkg::WEEKDAY_LIMIT:0];
        it.sched.day_wild = 1'($urandom_range(1));
        it.sched.weekday_wild = 1'($urandom_range(1));
        if ($urandom_range(6) != 0)
            it.when = cal_at($urandom_range(cat_pkg::WEEKDAY_LIMIT),
                             $urandom_range(cat_pkg::MONTH_LIMIT, 1),
                             $urandom_range(cat_pkg::DAY_LIMIT, 1),
                             $urandom_range(cat_pkg::HOUR_LIMIT),
                             $urandom_range(cat_pkg::MINUTE_LIMIT));
        else
            it.when = cat_pkg::cal_time_t'(23'($urandom_range(23'h7FFFFF)));
        return it;
    endfunction

    function automatic plan_row_t row(cat_pkg::cmd_t cmd, logic [15:0] tag,
                                      cat_pkg::sched_t s, cat_pkg::cal_time_t t,
                                      bit typed, cat_pkg::status_t want);
        plan_row_t p;
        p.item = '{cmd, tag, s, t};
        p.typed = typed;
        p.want = want;
        return p;
    endfunction

    task automatic send_item(alarm_item_t it, bit typed, cat_pkg::status_t want);
        alarm_result_t w;
        s_axis_tdata  <= {7'b0, it.when, it.sched, it.tag};
        s_axis_tuser  <= it.cmd;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready))
            @(posedge clk);
        apply_to_table(it);
        if (typed)
        begin
            void'(pending_results.pop_back());
            w = '{want, 1'b0, 16'h0, 1'b1};
            pending_results.push_back(w);
        end
    endtask

    bit tx_quiet = 1'b0;

    task automatic sender_gap();
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(14);
        if ($urandom_range(15) == 0)
            tx_quiet = !tx_quiet;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin : stimulus
        plan_row_t       plan [$];
        alarm_item_t     it;
        bit              growing;
        cat_pkg::sched_t only_dom;
        cat_pkg::sched_t only_dow;
        cat_pkg::sched_t either;

        tag_pool[0] = 16'h0000;
        tag_pool[1] = 16'hFFFF;
        for (int i = 2; i < TAG_POOL; i++)
            tag_pool[i] = 16'($urandom_range(16'hFFFF));

        // day 5 with a weekday star; weekday 3 with a day star; day 10 or weekday 3
        only_dom = cat_pkg::sched_t'({1'b1, 1'b0, 7'h7F, 13'h1FFE, 32'h20, 24'hFFFFFF,
                                      {60{1'b1}}});
        only_dow = cat_pkg::sched_t'({1'b0, 1'b1, 7'h08, 13'h1FFE, 32'hFFFFFFFE, 24'hFFFFFF,
                                      {60{1'b1}}});
        either   = cat_pkg::sched_t'({1'b0, 1'b0, 7'h08, 13'h1FFE, 32'h400, 24'hFFFFFF,
                                      {60{1'b1}}});

        plan.push_back(row(cat_pkg::CMD_TICK, 16'h0000, '0, cal_at(0, 1, 1, 0, 0),
                           1, cat_pkg::STAT_OK));
        plan.push_back(row(cat_pkg::CMD_REMOVE, 16'h0005, '0, '0, 1, cat_pkg::STAT_NOT_FOUND));
        plan.push_back(row(CMD_UNUSED, 16'hFFFF, '1, '1, 1, cat_pkg::STAT_OK));
        plan.push_back(row(cat_pkg::CMD_ADD, 16'hFFFF, '1, '0, 1, cat_pkg::STAT_OK));
        plan.push_back(row(cat_pkg::CMD_ADD, 16'hFFFF, '0, '0, 1, cat_pkg::STAT_DUPLICATE));
        plan.push_back(row(cat_pkg::CMD_ADD, 16'h0000, '0, '0, 1, cat_pkg::STAT_OK));
        plan.push_back(row(cat_pkg::CMD_TICK, 16'h0000, '0, cal_at(6, 12, 31, 23, 59),
                           0, cat_pkg::STAT_OK));
        plan.push_back(row(cat_pkg::CMD_TICK, 16'h0000, '0, cal_at(0, 1, 1, 0, 0),
                           0, cat_pkg::STAT_OK));
        plan.push_back(row(cat_pkg::CMD_TICK, 16'h0000, '0, cal_at(3, 6, 15, 12, 63),
                           0, cat_pkg::STAT_OK));
        plan.push_back(row(cat_pkg::CMD_TICK, 16'h0000, '0, cal_at(3, 6, 15, 31, 0),
                           0, cat_pkg::STAT_OK));
        plan.push_back(row(cat_pkg::CMD_TICK, 16'h0000, '0, cal_at(7, 6, 0, 12, 30),
                           0, cat_pkg::STAT_OK));
        plan.push_back(row(cat_pkg::CMD_TICK, 16'h0000, '0, cal_at(3, 0, 15, 12, 30),
                           0, cat_pkg::STAT_OK));
        plan.push_back(row(cat_pkg::CMD_TICK, 16'h0000, '0, cal_at(3, 15, 15, 12, 30),
                           0, cat_pkg::STAT_OK));
        plan.push_back(row(cat_pkg::CMD_ADD, 16'h0001, only_dom, '0, 1, cat_pkg::STAT_OK));
        plan.push_back(row(cat_pkg::CMD_ADD, 16'h0002, only_dow, '0, 1, cat_pkg::STAT_OK));
        plan.push_back(row(cat_pkg::CMD_ADD, 16'h0003, either, '0, 1, cat_pkg::STAT_OK));
        plan.push_back(row(cat_pkg::CMD_TICK, 16'h0000, '0, cal_at(0, 5, 10, 8, 20),
                           0, cat_pkg::STAT_OK));
        plan.push_back(row(cat_pkg::CMD_TICK, 16'h0000, '0, cal_at(3, 5, 5, 8, 20),
                           0, cat_pkg::STAT_OK));
        plan.push_back(row(cat_pkg::CMD_TICK, 16'h0000, '0, cal_at(2, 5, 7, 8, 20),
                           0, cat_pkg::STAT_OK));
        plan.push_back(row(cat_pkg::CMD_REMOVE, 16'hFFFF, '0, '0, 1, cat_pkg::STAT_OK));
        plan.push_back(row(cat_pkg::CMD_REMOVE, 16'hFFFF, '0, '0, 1, cat_pkg::STAT_NOT_FOUND));
        plan.push_back(row(cat_pkg::CMD_TICK, 16'h0000, '0, cal_at(3, 5, 5, 8, 20),
                           0, cat_pkg::STAT_OK));
        plan.push_back(row(cat_pkg::CMD_REMOVE, 16'h0003, '0, '0, 1, cat_pkg::STAT_OK));
        plan.push_back(row(cat_pkg::CMD_TICK, 16'h0000, '0, '1, 0, cat_pkg::STAT_OK));

        wait (rst_n);
        @(posedge clk);
        foreach (plan[i])
        begin
            send_item(plan[i].item, plan[i].typed, plan[i].want);
            sender_gap();
        end

        s_axis_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        @(posedge clk);

        // fill the table to the top, linger at full, then drain it, and again
        growing = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (table_count == 0)
                growing = 1'b1;
            else if (table_count == cat_pkg::MAX_ENTRIES && $urandom_range(7) == 0)
                growing = 1'b0;
            it = random_item(growing);
            send_item(it, 0, cat_pkg::STAT_OK);
            if (n == RANDOM_ITEMS / 2)
            begin
                s_axis_tvalid <= 1'b0;
                wait (pending_results.size() == 0);
                @(posedge clk);
            end
            else
                sender_gap();
        end
        s_axis_tvalid <= 1'b0;

        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin : receiver
        bit rx_quiet;
        bit held;
        int stall;
        rx_quiet = 1'b0;
        held = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = rx_quiet ? 0 : $urandom_range(14);
            if ($urandom_range(15) == 0)
                rx_quiet = !rx_quiet;
            // one long hold-off so the block backs up into its input
            if (!held && results_seen >= HOLD_AFTER)
            begin
                held = 1'b1;
                stall = LONG_HOLD;
            end
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready))
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : result_watch
        alarm_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                report_mismatch("beat with nothing pending, fired_id", m_axis_tdata, 0);
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tuser[1:0] !== want.status)
                    report_mismatch("status", m_axis_tuser[1:0], want.status);
                if (m_axis_tuser[2] !== want.fired)
                    report_mismatch("fired", m_axis_tuser[2], want.fired);
                if (m_axis_tdata !== want.tag)
                    report_mismatch("fired_id", m_axis_tdata, want.tag);
                if (m_axis_tlast !== want.last)
                    report_mismatch("last", m_axis_tlast, want.last);
            end
        end
    end

endmodule
